### hdl/aks_pkg.sv
// Package for the ascending key sort unit: key width, default capacity and
// the item type that travels between the sort cells. No dependencies.
`timescale 1ns / 1ps

package aks_pkg;

    localparam int KEY_W           = 32;
    localparam int MAX_RECORDS_DEF = 64;
    localparam int STORE_DEPTH     = 64;

    // one key slot: occupancy flag and signed key
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
    } sort_item_t;

endpackage

### hdl/ascending_key_sort_unit.sv
// Top level of the ascending key sort unit: batch control, the row of sort
// cells and the output register. Depends on aks_pkg and aks_cell.
`timescale 1ns / 1ps

// Sorts a batch of signed 32-bit keys into ascending order. Keys arrive one
// beat per cycle on the s_ side while s_tready is high; s_tlast closes the
// batch. Up to MAX_RECORDS keys are kept, later keys of the same batch are
// dropped (the closing tlast still ends the batch). Each key enters a row of
// MAX_RECORDS cells and ripples upward one cell per cycle, every cell keeping
// the smaller key. After the closing beat the row settles, during which
// s_tready is low, then the keys are shifted out of the bottom cell one per
// cycle while m_tready allows, smallest first, with m_tlast on the last one.
// A new batch may start loading while the final beat of the previous one
// still waits in the output register.
module ascending_key_sort_unit
#(
    parameter int MAX_RECORDS = aks_pkg::MAX_RECORDS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [aks_pkg::KEY_W-1:0] s_tdata,  // [31:0] record_key
    input  logic                     s_tlast,   // batch_end
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [aks_pkg::KEY_W-1:0] m_tdata,  // [31:0] sorted_key
    output logic                     m_tlast    // final_out
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    // control states
    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_UNLOAD = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;   // keys held, then keys still to emit
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] settle_reg;
    logic [CNT_W-1:0] settle_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [aks_pkg::KEY_W-1:0] out_key_reg;
    logic                    out_last_reg;

    logic in_beat;
    logic has_room;
    logic take_out;
    logic shift_en;

    aks_pkg::sort_item_t ins_item;
    aks_pkg::sort_item_t pass_w [MAX_RECORDS];
    aks_pkg::sort_item_t held_w [MAX_RECORDS];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_RECORDS));
    assign take_out = !out_valid_reg || m_tready;
    assign shift_en = (state_reg == ST_UNLOAD) && take_out;

    assign ins_item.valid = in_beat && has_room;
    assign ins_item.key   = s_tdata;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        settle_next    = settle_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next  = ST_SETTLE;
                        settle_next = CNT_W'(MAX_RECORDS);
                    end
                end
            end
            ST_SETTLE:
            begin
                settle_next = settle_reg - CNT_W'(1);
                if (settle_reg == CNT_W'(1))
                begin
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD:
            begin
                if (take_out)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            settle_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            settle_reg    <= settle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload: bottom cell holds the smallest remaining key
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            out_key_reg  <= held_w[0].key;
            out_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    // the cell row; top cell's handed-on key never occurs (capacity bound)
    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            aks_pkg::sort_item_t cell_ins;
            aks_pkg::sort_item_t cell_shift;

            if (gi == 0)
            begin : g_first
                assign cell_ins = ins_item;
            end
            else
            begin : g_rest
                assign cell_ins = pass_w[gi-1];
            end

            if (gi == MAX_RECORDS - 1)
            begin : g_top
                assign cell_shift = '0;
            end
            else
            begin : g_mid
                assign cell_shift = held_w[gi+1];
            end

            aks_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .ins_in   (cell_ins),
                .shift_in (cell_shift),
                .ins_out  (pass_w[gi]),
                .held     (held_w[gi])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hdl/aks_cell.sv
// One cell of the sorting chain: holds one key, keeps the smaller of held and
// incoming key, passes the larger one on. Depends on aks_pkg.
`timescale 1ns / 1ps

module aks_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,  // unload: take neighbour's held key
    input  aks_pkg::sort_item_t ins_in,   // key arriving from the lower cell
    input  aks_pkg::sort_item_t shift_in, // held key of the upper cell
    output aks_pkg::sort_item_t ins_out,  // key handed to the upper cell
    output aks_pkg::sort_item_t held      // key kept here
);

    aks_pkg::sort_item_t held_reg;
    aks_pkg::sort_item_t held_next;
    aks_pkg::sort_item_t pass_reg;
    aks_pkg::sort_item_t pass_next;

    always_comb
    begin
        held_next = held_reg;
        pass_next = '0;
        if (shift_en)
        begin
            held_next = shift_in;
        end
        else if (ins_in.valid)
        begin
            if (!held_reg.valid)
            begin
                held_next = ins_in;
            end
            else if (ins_in.key < held_reg.key)
            begin
                held_next = ins_in;
                pass_next = held_reg;
            end
            else
            begin
                pass_next = ins_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end

    assign ins_out = pass_reg;
    assign held    = held_reg;

endmodule

### hdl/aks_checker.sv
// Port-level checker for the ascending key sort unit, bound to the top
// level. Depends on aks_pkg.
`timescale 1ns / 1ps

module aks_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [aks_pkg::KEY_W-1:0] s_tdata,
    input logic                     s_tlast,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [aks_pkg::KEY_W-1:0] m_tdata,
    input logic                     m_tlast
);

    logic                           mid_batch_reg;
    logic signed [aks_pkg::KEY_W-1:0] prev_key_reg;
    logic                           out_beat;

    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_batch_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            mid_batch_reg <= !m_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_beat)
        begin
            prev_key_reg <= $signed(m_tdata);
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // keys of one batch leave in ascending signed order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && mid_batch_reg |-> $signed(m_tdata) >= prev_key_reg)
        else $error("result keys out of order");

    // the closing beat stops intake while the batch is sorted
    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("intake open right after closing beat");

    // no result beat shows up straight after a closing beat taken while none was showing
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result beat appeared during settle");

endmodule

bind ascending_key_sort_unit aks_checker u_aks_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/tb_ascending_key_sort_unit.sv
// Self-checking testbench for ascending_key_sort_unit: batches of signed keys
// go in, an in-bench exchange-sort predictor builds the expected beats.
// Depends on aks_pkg and the ascending_key_sort_unit RTL only.
`timescale 1ns / 1ps

module tb_ascending_key_sort_unit;

    // keys the block keeps per batch (MAX_RECORDS_DEF), capped in the bench at STORE_DEPTH
    localparam int CAPACITY = (aks_pkg::MAX_RECORDS_DEF > aks_pkg::STORE_DEPTH)
                              ? aks_pkg::STORE_DEPTH : aks_pkg::MAX_RECORDS_DEF;
    // quiet spell at the end, long enough for a row settle and a full unload
    localparam int DRAIN_CYCLES = 4 * CAPACITY;

    typedef logic signed [aks_pkg::KEY_W-1:0] key_t;

    // one expected output beat
    typedef struct {
        key_t key;
        logic last;
    } sorted_beat_t;

    typedef enum int { KEY_ANY, KEY_NARROW, KEY_EDGE } key_style_e;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [aks_pkg::KEY_W-1:0] s_tdata;   // [31:0] record_key
    logic         s_tlast;                // batch_end
    logic         m_tvalid;
    logic         m_tready;
    logic [aks_pkg::KEY_W-1:0] m_tdata;   // [31:0] sorted_key
    logic         m_tlast;                // final_out

    key_t         held_keys[$];      // keys of the batch being collected
    sorted_beat_t sorted_expect[$];  // beats still owed by the block

    int  error_count   = 0;
    int  keys_sent     = 0;
    int  batches_sent  = 0;
    int  beats_checked = 0;
    bit  src_idle_on   = 1'b0;
    bit  sink_stall_on = 1'b0;
    int  sink_stall_left = 0;

    ascending_key_sort_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake
    initial
    begin
        #5ms;
        $display("Timeout: %0d beats still expected", sorted_expect.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Batch closes: exchange sort of the held keys, one expected beat per key
    task automatic close_batch();
        key_t swap_key;
        for (int i = 0; i < held_keys.size(); i++)
        begin
            for (int j = i + 1; j < held_keys.size(); j++)
            begin
                if (held_keys[i] > held_keys[j])
                begin
                    swap_key     = held_keys[i];
                    held_keys[i] = held_keys[j];
                    held_keys[j] = swap_key;
                end
            end
        end
        foreach (held_keys[k])
            sorted_expect.push_back('{key: held_keys[k], last: (k == held_keys.size() - 1)});
        held_keys.delete();
        batches_sent++;
    endtask

    // Drive one key beat, wait for acceptance and update the predictor.
    // Enters and leaves at a falling edge; s_tvalid stays high between beats unless idle gaps are on.
    task automatic send_key(input key_t key, input logic last);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        keys_sent++;
        if (held_keys.size() < CAPACITY)
            held_keys.push_back(key);
        if (last)
            close_batch();
        @(negedge clk);
    endtask

    function automatic key_t pick_key(input key_style_e style);
        key_t key;
        case (style)
            KEY_NARROW: key = $signed($urandom_range(0, 8)) - 4;   // many duplicates
            KEY_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0:       key = 32'sh8000_0000;
                    1:       key = 32'sh7fff_ffff;
                    2:       key = 32'sh0000_0000;
                    3:       key = -32'sd1;
                    4:       key = 32'sh8000_0001;
                    default: key = 32'sh7fff_fffe;
                endcase
            end
            default:    key = $urandom;
        endcase
        return key;
    endfunction

    // Receiver: random stall bursts while enabled, otherwise always ready
    always @(negedge clk)
    begin
        if (!sink_stall_on)
            m_tready <= 1'b1;
        else if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            sink_stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Output checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin : check_output
        sorted_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_expect.size() == 0)
                report_mismatch($sformatf("unexpected beat key=%0d last=%0b",
                                          $signed(m_tdata), m_tlast));
            else
            begin
                want = sorted_expect.pop_front();
                beats_checked++;
                if (m_tdata !== want.key)
                    report_mismatch($sformatf("sorted_key got %0d want %0d",
                                              $signed(m_tdata), want.key));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("final_out got %0b want %0b (key %0d)",
                                              m_tlast, want.last, want.key));
            end
        end
    end

    // Single-key batches at the extremes, then mixed orderings and duplicates
    task automatic test_directed();
        key_t edge_keys[7] = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1,
                               32'sh8000_0001, 32'sh7fff_fffe};
        key_t dup_keys[5]  = '{5, 5, -5, 5, -5};
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        send_key(32'sh8000_0000, 1'b1);
        send_key(32'sh7fff_ffff, 1'b1);
        send_key(0, 1'b1);
        send_key(-1, 1'b1);
        foreach (edge_keys[i])
            send_key(edge_keys[i], i == 6);
        foreach (dup_keys[i])
            send_key(dup_keys[i], i == 4);
        // already descending
        for (int i = 0; i < 5; i++)
            send_key(100 - 30 * i, i == 4);
    endtask

    // Exactly full batch (closing key stored), then an overfull one whose
    // extra keys and closing key are dropped
    task automatic test_store_full();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
            send_key($urandom, i == CAPACITY - 1);
        src_idle_on = 1'b1;
        for (int i = 0; i < CAPACITY + 6; i++)
            send_key(pick_key(i % 2 ? KEY_EDGE : KEY_ANY), i == CAPACITY + 5);
    endtask

    // Random batches, mostly short, now and then around the store size
    task automatic test_random_batches(input int item_goal);
        int         batch_len;
        key_style_e style;
        while (keys_sent < item_goal)
        begin
            src_idle_on   = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0)
                batch_len = $urandom_range(CAPACITY - 4, CAPACITY + 4);
            else
                batch_len = $urandom_range(1, 12);
            style = key_style_e'($urandom_range(KEY_ANY, KEY_EDGE));
            for (int k = 0; k < batch_len; k++)
                send_key(pick_key(style), k == batch_len - 1);
        end
    endtask

    // Closing stretch: no idling on either side, batches back to back
    task automatic test_back_to_back();
        int lens[6] = '{1, 2, 3, 5, 8, 11};
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        foreach (lens[b])
            for (int k = 0; k < lens[b]; k++)
                send_key(pick_key(KEY_ANY), k == lens[b] - 1);
    endtask

    initial
    begin
        int wait_cycles;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_store_full();
        test_random_batches(400);
        test_back_to_back();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // wait for every owed beat, bounded
        wait_cycles = 0;
        while (sorted_expect.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (sorted_expect.size() != 0)
        begin
            $display("Timeout: %0d beats never arrived", sorted_expect.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (sorted_expect.size() != 0)
                report_mismatch("expectations left over at the end");
            $display("Sent %0d key beats in %0d batches (full and overfull included);",
                     keys_sent, batches_sent);
            $display("checked %0d sorted beats, %0d mismatches.",
                     beats_checked, error_count);
            if (error_count == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
